FILE: sv/qpud_pkg.sv
// Package for the quoted percent decoder: beat types, the decoder state record and the
// character and UTF-8 constants. No dependencies; every other file imports it.
package qpud_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_t;

  typedef struct packed {
    logic [7:0] decoded_byte;
    logic       decoded_present;
    logic       done_res;
    logic       failed;
  } out_t;

  typedef enum logic [1:0] {
    PH_OPEN = 2'd0,
    PH_BODY = 2'd1,
    PH_HEX1 = 2'd2,
    PH_HEX2 = 2'd3
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic        error_seen;
    logic [3:0]  high_nibble;
    logic [1:0]  utf8_remaining;
    logic [1:0]  utf8_total;
    logic [20:0] code_point;
  } qpud_state_t;

  localparam qpud_state_t STATE_RESET = '{
    phase:          PH_OPEN,
    error_seen:     1'b0,
    high_nibble:    4'd0,
    utf8_remaining: 2'd0,
    utf8_total:     2'd0,
    code_point:     21'd0
  };

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_TILDE   = 8'h7e;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;

  localparam logic [7:0] LEAD2_LO = 8'hc2;
  localparam logic [7:0] LEAD2_HI = 8'hdf;
  localparam logic [7:0] LEAD3_LO = 8'he0;
  localparam logic [7:0] LEAD3_HI = 8'hef;
  localparam logic [7:0] LEAD4_LO = 8'hf0;
  localparam logic [7:0] LEAD4_HI = 8'hf4;
  localparam logic [7:0] CONT_MASK = 8'hc0;
  localparam logic [7:0] CONT_TAG  = 8'h80;

  localparam logic [20:0] CP_MIN3    = 21'h000800;
  localparam logic [20:0] CP_MIN4    = 21'h010000;
  localparam logic [20:0] CP_MAX     = 21'h10ffff;
  localparam logic [20:0] CP_SURR_LO = 21'h00d800;
  localparam logic [20:0] CP_SURR_HI = 21'h00dfff;

  // Bit 4 flags a valid hex digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      r = {1'b1, 4'(c - CH_ZERO)};
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
      r = {1'b1, 4'(c - CH_UPPER_A + 8'd10)};
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
      r = {1'b1, 4'(c - CH_LOWER_A + 8'd10)};
    end
    return r;
  endfunction

  function automatic logic permitted(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_BANG) || (c >= CH_HASH && c <= CH_DOLLAR) ||
           (c >= CH_AMP && c <= CH_TILDE);
  endfunction

endpackage

FILE: sv/qpud_in_stage.sv
// Input register of the quoted percent decoder: holds one beat until the decode stage takes it.
// Depends on qpud_pkg for the input beat type.
module qpud_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  qpud_pkg::in_t in_data,
  input  logic          advance,
  output logic          s1_valid,
  output qpud_pkg::in_t s1_data
);
  import qpud_pkg::*;

  logic s1_valid_r;
  in_t  s1_data_r;

  assign in_stall = s1_valid_r && !advance;
  assign s1_valid = s1_valid_r;
  assign s1_data  = s1_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data;
    end
  end

endmodule

FILE: sv/qpud_step.sv
// Per-byte decode logic: quote framing, percent unescaping and strict UTF-8 checking.
// Purely combinational; depends on qpud_pkg for types, constants and helper functions.
module qpud_step (
  input  qpud_pkg::in_t        item,
  input  qpud_pkg::qpud_state_t st,
  output qpud_pkg::qpud_state_t st_nxt,
  output qpud_pkg::out_t       res
);
  import qpud_pkg::*;

  logic [4:0]  hex;
  logic [7:0]  b;

  assign b   = item.in_byte;
  assign hex = hex_digit(b);

  always_comb begin
    qpud_state_t nxt;
    logic        emit;
    logic [7:0]  value;
    logic        bad;
    logic        utf_bad;
    logic [20:0] cp;
    logic [1:0]  rem;
    nxt     = st;
    emit    = 1'b0;
    value   = 8'd0;
    bad     = 1'b0;
    utf_bad = 1'b0;
    cp      = st.code_point;
    rem     = st.utf8_remaining;
    if (item.end_of_string) begin
      bad = st.error_seen || (st.phase != PH_BODY) || (b != CH_QUOTE) ||
            (st.utf8_remaining != 2'd0);
      nxt = STATE_RESET;
    end else if (!st.error_seen) begin
      unique case (st.phase)
        PH_OPEN: begin
          if (b == CH_QUOTE) nxt.phase = PH_BODY;
          else nxt.error_seen = 1'b1;
        end
        PH_BODY: begin
          priority if (b == CH_PERCENT) begin
            nxt.phase = PH_HEX1;
          end else if (permitted(b)) begin
            emit  = 1'b1;
            value = b;
          end else begin
            nxt.error_seen = 1'b1;
          end
        end
        PH_HEX1: begin
          if (!hex[4]) begin
            nxt.error_seen = 1'b1;
          end else begin
            nxt.high_nibble = hex[3:0];
            nxt.phase       = PH_HEX2;
          end
        end
        PH_HEX2: begin
          if (!hex[4]) begin
            nxt.error_seen = 1'b1;
          end else begin
            value     = {st.high_nibble, hex[3:0]};
            emit      = 1'b1;
            nxt.phase = PH_BODY;
          end
        end
        default: nxt.error_seen = 1'b1;
      endcase
      if (emit) begin
        if (st.utf8_remaining == 2'd0) begin
          priority if (value == 8'd0) begin
            utf_bad = 1'b1;
          end else if (!value[7]) begin
            utf_bad = 1'b0;
          end else if (value >= LEAD2_LO && value <= LEAD2_HI) begin
            nxt.code_point     = {16'd0, value[4:0]};
            nxt.utf8_total     = 2'd1;
            nxt.utf8_remaining = 2'd1;
          end else if (value >= LEAD3_LO && value <= LEAD3_HI) begin
            nxt.code_point     = {17'd0, value[3:0]};
            nxt.utf8_total     = 2'd2;
            nxt.utf8_remaining = 2'd2;
          end else if (value >= LEAD4_LO && value <= LEAD4_HI) begin
            nxt.code_point     = {18'd0, value[2:0]};
            nxt.utf8_total     = 2'd3;
            nxt.utf8_remaining = 2'd3;
          end else begin
            utf_bad = 1'b1;
          end
        end else if ((value & CONT_MASK) != CONT_TAG) begin
          utf_bad = 1'b1;
        end else begin
          cp                 = {st.code_point[14:0], value[5:0]};
          rem                = st.utf8_remaining - 2'd1;
          nxt.code_point     = cp;
          nxt.utf8_remaining = rem;
          if (rem == 2'd0) begin
            if (st.utf8_total == 2'd2 && cp < CP_MIN3) utf_bad = 1'b1;
            if (st.utf8_total == 2'd3 && cp < CP_MIN4) utf_bad = 1'b1;
            if (cp > CP_MAX) utf_bad = 1'b1;
            if (cp >= CP_SURR_LO && cp <= CP_SURR_HI) utf_bad = 1'b1;
          end
        end
        if (utf_bad) nxt.error_seen = 1'b1;
      end
    end
    st_nxt              = nxt;
    res.decoded_byte    = emit ? value : 8'd0;
    res.decoded_present = emit;
    res.done_res        = item.end_of_string;
    res.failed          = item.end_of_string && bad;
  end

endmodule

FILE: sv/quoted_percent_utf8_decoder_unit.sv
// Top level of the quoted percent decoder: input register, decode state and result register.
// Depends on qpud_pkg, qpud_in_stage and qpud_step.
//
// Usage: a double-quoted string arrives one byte per beat on the in_ channel, with
// end_of_string set on the last byte. Every input beat yields exactly one result beat on
// the out_ channel. A content byte, after %XX unescaping, appears with decoded_present set.
// The beat for the last byte carries done_res and, in failed, the verdict on quoting,
// escapes and strict UTF-8. A receiver drops the decoded bytes of a string that failed.
// A byte accepted into the input register is decoded on its way into the result register.
// One byte per cycle while no result beat is held by out_stall; the per-byte state update is a single pass of logic
// between the input register and the result register.
// Reset clears the decode state to "expect opening quote" and empties both registers.
// When out_stall is high the result register holds its beat; the input register still
// takes a byte if it is empty, after which in_stall rises until the result beat moves on.
// After the last byte of a string the state returns to its reset values for the next one.
module quoted_percent_utf8_decoder_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  qpud_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output qpud_pkg::out_t out_data
);
  import qpud_pkg::*;

  logic        s1_valid;
  in_t         s1_data;
  logic        advance;
  qpud_state_t state_r;
  qpud_state_t state_nxt;
  out_t        res;
  out_t        out_r;
  logic        out_valid_r;

  assign advance = s1_valid && (!out_valid_r || !out_stall);

  qpud_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_data  (s1_data)
  );

  qpud_step u_step (
    .item   (s1_data),
    .st     (state_r),
    .st_nxt (state_nxt),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= STATE_RESET;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_reset_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_data.end_of_string |=> state_r.phase == PH_OPEN && !state_r.error_seen &&
    state_r.utf8_remaining == 2'd0)
    else $error("decode state not cleared after last byte");

  a_no_emit_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.done_res |-> !out_r.decoded_present)
    else $error("content byte emitted on last beat");

  a_failed_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.failed |-> out_r.done_res)
    else $error("failed set without done");

  a_no_emit_after_error: assert property (@(posedge clk) disable iff (!rst_n)
    advance && state_r.error_seen |=> !out_r.decoded_present)
    else $error("byte emitted after sticky error");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid && out_valid_r && out_stall)
    else $error("input stalled while pipeline can move");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for quoted_percent_utf8_decoder_unit. It sends directed and random
// quoted strings, predicts every result beat with its own decoder model and compares them.
// Depends on qpud_pkg and the decoder RTL.

module tb;
  import qpud_pkg::*;

  localparam int RANDOM_ITEMS = 1950;
  localparam int QUIET_TAIL   = 300;
  localparam int CYCLE_LIMIT  = 500000;

  class decode_scoreboard;
    phase_t      phase;
    logic        err;
    logic [3:0]  hi_nib;
    logic [1:0]  cont_left;
    logic [1:0]  cont_total;
    logic [20:0] cp;
    out_t        expected_q[$];
    int          mismatches;
    int          beats_checked;
    int          strings_done;
    int          strings_failed;

    function new();
      clear_state();
      mismatches = 0;
      beats_checked = 0;
      strings_done = 0;
      strings_failed = 0;
    endfunction

    function void clear_state();
      phase = PH_OPEN;
      err = 1'b0;
      hi_nib = 4'd0;
      cont_left = 2'd0;
      cont_total = 2'd0;
      cp = 21'd0;
    endfunction

    function int nibble_of(logic [7:0] c);
      if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
      if (c >= CH_UPPER_A && c <= CH_UPPER_F) return int'(c - CH_UPPER_A) + 10;
      if (c >= CH_LOWER_A && c <= CH_LOWER_F) return int'(c - CH_LOWER_A) + 10;
      return -1;
    endfunction

    function bit is_plain(logic [7:0] c);
      return c == CH_SPACE || c == CH_BANG || (c >= CH_HASH && c <= CH_DOLLAR) ||
             (c >= CH_AMP && c <= CH_TILDE);
    endfunction

    function bit utf8_accept(logic [7:0] b);
      if (cont_left == 2'd0) begin
        if (b == 8'h00) return 1'b0;
        if (b < 8'h80) return 1'b1;
        if (b >= LEAD2_LO && b <= LEAD2_HI) begin
          cp = 21'(b[4:0]);
          cont_total = 2'd1;
        end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
          cp = 21'(b[3:0]);
          cont_total = 2'd2;
        end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
          cp = 21'(b[2:0]);
          cont_total = 2'd3;
        end else begin
          return 1'b0;
        end
        cont_left = cont_total;
        return 1'b1;
      end
      if ((b & CONT_MASK) != CONT_TAG) return 1'b0;
      cp = {cp[14:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      if (cont_left != 2'd0) return 1'b1;
      if (cont_total == 2'd2 && cp < CP_MIN3) return 1'b0;
      if (cont_total == 2'd3 && cp < CP_MIN4) return 1'b0;
      if (cp > CP_MAX) return 1'b0;
      if (cp >= CP_SURR_LO && cp <= CP_SURR_HI) return 1'b0;
      return 1'b1;
    endfunction

    function void note_input(in_t beat);
      out_t       res;
      logic       emit;
      logic [7:0] val;
      int         h;
      res = '0;
      emit = 1'b0;
      val = 8'h00;
      if (beat.end_of_string) begin
        res.done_res = 1'b1;
        res.failed = err || phase != PH_BODY || beat.in_byte != CH_QUOTE || cont_left != 2'd0;
        strings_done++;
        if (res.failed) strings_failed++;
        clear_state();
      end else if (!err) begin
        h = nibble_of(beat.in_byte);
        case (phase)
          PH_OPEN: begin
            if (beat.in_byte == CH_QUOTE) phase = PH_BODY;
            else err = 1'b1;
          end
          PH_BODY: begin
            if (beat.in_byte == CH_PERCENT) begin
              phase = PH_HEX1;
            end else if (is_plain(beat.in_byte)) begin
              emit = 1'b1;
              val = beat.in_byte;
            end else begin
              err = 1'b1;
            end
          end
          PH_HEX1: begin
            if (h < 0) begin
              err = 1'b1;
            end else begin
              hi_nib = h[3:0];
              phase = PH_HEX2;
            end
          end
          default: begin
            if (h < 0) begin
              err = 1'b1;
            end else begin
              val = {hi_nib, h[3:0]};
              emit = 1'b1;
              phase = PH_BODY;
            end
          end
        endcase
        if (emit && !utf8_accept(val)) err = 1'b1;
        res.decoded_present = emit;
        res.decoded_byte = emit ? val : 8'h00;
      end
      expected_q.push_back(res);
    endfunction

    function void check_result(out_t got);
      out_t exp_beat;
      beats_checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result beat %0d arrived with nothing expected (%h)",
                   beats_checked, got);
        return;
      end
      exp_beat = expected_q.pop_front();
      if (got.decoded_byte !== exp_beat.decoded_byte ||
          got.decoded_present !== exp_beat.decoded_present ||
          got.done_res !== exp_beat.done_res || got.failed !== exp_beat.failed) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: beat %0d expected byte %h present %b done %b failed %b, %s %h %b %b %b",
                   beats_checked, exp_beat.decoded_byte, exp_beat.decoded_present,
                   exp_beat.done_res, exp_beat.failed, "got",
                   got.decoded_byte, got.decoded_present, got.done_res, got.failed);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  decode_scoreboard sb = new();
  bit   tx_idle_en = 1'b1;
  logic rx_idle_en = 1'b1;
  int   stall_left = 0;
  int   cycle_count = 0;
  int   bytes_sent = 0;

  quoted_percent_utf8_decoder_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 12);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_beat(input in_t beat);
    int unsigned gap;
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (in_stall);
    sb.note_input(beat);
    bytes_sent++;
    gap = (tx_idle_en && $urandom_range(0, 7) == 0) ? $urandom_range(1, 13) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_bytes(input logic [7:0] q[$]);
    in_t beat;
    foreach (q[i]) begin
      beat.in_byte = q[i];
      beat.end_of_string = (i == q.size() - 1);
      send_beat(beat);
    end
  endtask

  task automatic send_text(input string s);
    logic [7:0] q[$];
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    send_bytes(q);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_q.size() != 0);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return CH_ZERO + n;
    return ($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + n - 8'd10;
  endfunction

  task automatic put_esc(ref logic [7:0] q[$], input logic [7:0] b);
    q.push_back(CH_PERCENT);
    q.push_back(hex_char(b[7:4]));
    q.push_back(hex_char(b[3:0]));
  endtask

  task automatic put_utf8(ref logic [7:0] q[$], input int unsigned cpv);
    if (cpv < 'h80) begin
      if (sb.is_plain(cpv[7:0]) && $urandom_range(0, 1)) q.push_back(cpv[7:0]);
      else put_esc(q, cpv[7:0]);
    end else if (cpv < 'h800) begin
      put_esc(q, {3'b110, cpv[10:6]});
      put_esc(q, {2'b10, cpv[5:0]});
    end else if (cpv < 'h10000) begin
      put_esc(q, {4'b1110, cpv[15:12]});
      put_esc(q, {2'b10, cpv[11:6]});
      put_esc(q, {2'b10, cpv[5:0]});
    end else begin
      put_esc(q, {5'b11110, cpv[20:18]});
      put_esc(q, {2'b10, cpv[17:12]});
      put_esc(q, {2'b10, cpv[11:6]});
      put_esc(q, {2'b10, cpv[5:0]});
    end
  endtask

  task automatic put_good(ref logic [7:0] q[$]);
    int unsigned corner_cps[10] = '{'h1, 'h7f, 'h80, 'h7ff, 'h800, 'hd7ff, 'he000, 'hffff,
                                    'h10000, 'h10ffff};
    int unsigned cpv;
    logic [7:0]  c;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        c = 8'($urandom_range(CH_SPACE, CH_TILDE));
        if (!sb.is_plain(c)) c = CH_AMP;
        q.push_back(c);
      end
      4: put_utf8(q, $urandom_range('h1, 'h7f));
      5, 6: put_utf8(q, $urandom_range('h80, 'h7ff));
      7: begin
        cpv = $urandom_range('h800, 'hffff);
        if (cpv >= 'hd800 && cpv <= 'hdfff) cpv -= 'h1000;
        put_utf8(q, cpv);
      end
      8: put_utf8(q, $urandom_range('h10000, 'h10ffff));
      default: put_utf8(q, corner_cps[$urandom_range(0, 9)]);
    endcase
  endtask

  task automatic put_bad(ref logic [7:0] q[$]);
    logic [7:0] b;
    case ($urandom_range(0, 11))
      0: put_esc(q, 8'h00);
      1: begin
        put_esc(q, {7'b1100000, 1'($urandom)});
        put_esc(q, {2'b10, 6'($urandom)});
      end
      2: begin
        put_esc(q, 8'he0);
        put_esc(q, {3'b100, 5'($urandom)});
        put_esc(q, {2'b10, 6'($urandom)});
      end
      3: begin
        put_esc(q, 8'hf0);
        put_esc(q, {4'b1000, 4'($urandom)});
        put_esc(q, {2'b10, 6'($urandom)});
        put_esc(q, {2'b10, 6'($urandom)});
      end
      4: begin
        put_esc(q, 8'hed);
        put_esc(q, {3'b101, 5'($urandom)});
        put_esc(q, {2'b10, 6'($urandom)});
      end
      5: begin
        put_esc(q, 8'hf4);
        put_esc(q, 8'($urandom_range(8'h90, 8'hbf)));
        put_esc(q, {2'b10, 6'($urandom)});
        put_esc(q, {2'b10, 6'($urandom)});
      end
      6: put_esc(q, 8'($urandom_range(8'hf5, 8'hff)));
      7: begin
        put_esc(q, 8'($urandom_range(8'hc2, 8'hf4)));
        b = 8'($urandom_range(1, 255));
        if (b[7:6] == 2'b10) b[6] = 1'b1;
        put_esc(q, b);
      end
      8: put_esc(q, {2'b10, 6'($urandom)});
      9: begin
        b = 8'($urandom);
        if (sb.is_plain(b) || b == CH_PERCENT) b[7] = 1'b1;
        q.push_back(b);
      end
      10: begin
        b = 8'($urandom);
        if (sb.nibble_of(b) >= 0) b = 8'h47;
        q.push_back(CH_PERCENT);
        if ($urandom_range(0, 1)) q.push_back(hex_char(4'($urandom)));
        q.push_back(b);
      end
      default: q.push_back(CH_QUOTE);
    endcase
  endtask

  task automatic random_string();
    logic [7:0]  body[$];
    int unsigned kind;
    int unsigned n;
    int unsigned bad_at;
    logic [7:0]  lead;
    kind = $urandom_range(0, 99);
    n = $urandom_range(0, 6);
    bad_at = (kind >= 70 && kind < 85) ? $urandom_range(0, n) : n + 1;
    body.push_back(CH_QUOTE);
    for (int i = 0; i <= n; i++) begin
      if (i == bad_at) put_bad(body);
      if (i < n) put_good(body);
    end
    if (kind >= 85 && kind < 88) body[0] = 8'($urandom);
    if (kind >= 88 && kind < 91) begin
      case ($urandom_range(0, 2))
        0: lead = 8'($urandom_range(8'hc2, 8'hdf));
        1: lead = 8'($urandom_range(8'he0, 8'hef));
        default: lead = 8'($urandom_range(8'hf0, 8'hf4));
      endcase
      put_esc(body, lead);
      if (lead >= LEAD3_LO && $urandom_range(0, 1)) put_esc(body, {2'b10, 6'($urandom)});
    end
    if (kind >= 91 && kind < 94) begin
      body.push_back(CH_PERCENT);
      if ($urandom_range(0, 1)) body.push_back(hex_char(4'($urandom)));
    end
    if (kind >= 94 && kind < 97) body.push_back(8'($urandom));
    else body.push_back(CH_QUOTE);
    if (kind >= 97) begin
      body.delete();
      repeat ($urandom_range(1, 6)) body.push_back(8'($urandom));
    end
    send_bytes(body);
  endtask

  initial begin
    int random_start;
    int strings_sent;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_text("\"\"");
    send_text("\"");
    send_text("\" ~%C2%bf\"");
    send_text("\"%0\"");
    send_text("\"ax");
    send_text("\"\"\"");
    send_text("\"%00!\"");
    wait_drained();

    random_start = bytes_sent;
    strings_sent = 0;
    while (bytes_sent - random_start < RANDOM_ITEMS) begin
      if (bytes_sent - random_start >= RANDOM_ITEMS - QUIET_TAIL) begin
        tx_idle_en = 1'b0;
        rx_idle_en <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        tx_idle_en = ($urandom_range(0, 2) != 0);
        rx_idle_en <= ($urandom_range(0, 2) != 0);
      end
      random_string();
      strings_sent++;
      if (strings_sent % 25 == 0) wait_drained();
    end

    wait_drained();
    repeat (4) @(posedge clk);
    $display("Run covered %0d input bytes in %0d strings, %0d of them rejected.",
             bytes_sent, sb.strings_done, sb.strings_failed);
    $display("%0d result beats checked, %0d mismatches.", sb.beats_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/qpud_pkg.sv
sv/qpud_in_stage.sv
sv/qpud_step.sv
sv/quoted_percent_utf8_decoder_unit.sv
tb/tb.sv
